/* hdl/npcs_pkg.sv */
// shared types, constants and codes for the nearest palette color search
// no dependencies; the other files, apart from npcs_ram, refer to this package by scoped names
package npcs_pkg;

    // palette geometry
    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field and arithmetic widths
    localparam int COLOR_W  = 8;
    localparam int WEIGHT_W = 4;
    localparam int SQ_W     = 2 * COLOR_W;
    localparam int TERM_W   = SQ_W + WEIGHT_W;
    localparam int DIST_W   = 22;
    localparam int ENTRY_W  = 3 * COLOR_W;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic [IDX_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [SQ_W-1:0]     sq_t;
    typedef logic [TERM_W-1:0]   term_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [CFG_W-1:0]    cfg_data_t;
    typedef logic [4:0]          best_index_t;

    // request codes
    typedef enum logic {
        REQ_QUERY = 1'b0,
        REQ_LOAD  = 1'b1
    } req_type_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_WEIGHT    = 2'd0,
        CFG_GREEN_WEIGHT  = 2'd1,
        CFG_BLUE_WEIGHT   = 2'd2,
        CFG_ENTRIES_IN_USE = 2'd3
    } cfg_index_t;

    // reset values of the configuration registers
    localparam weight_t   RED_WEIGHT_RST   = 4'd3;
    localparam weight_t   GREEN_WEIGHT_RST = 4'd4;
    localparam weight_t   BLUE_WEIGHT_RST  = 4'd2;
    localparam cfg_data_t ENTRIES_IN_USE_RST = 6'd32;

    // input and result words
    typedef struct packed {
        logic       req_type;
        logic [4:0] entry_index;
        color_t     red;
        color_t     green;
        color_t     blue;
    } in_word_t;

    typedef struct packed {
        best_index_t best_index;
        dist_t       min_dist;
    } out_word_t;

    typedef struct packed {
        weight_t red_weight;
        weight_t green_weight;
        weight_t blue_weight;
    } weights_t;

    // controller state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic  capture;
        logic  wr_en;
        logic  rd_en;
        addr_t rd_addr;
        logic  out_load;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic busy;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/nearest_palette_color_search.sv */
// top level of the nearest palette color search: config registers and wiring
// depends on npcs_pkg, npcs_ctrl, npcs_datapath (and npcs_ram below it)

// A load word writes one palette entry and gives no result; loads to an index
// at or beyond the palette depth are dropped. A query word scans entries 0
// through N-1, where N is entries_in_use clamped to 1..32, and gives one result
// word with the lowest-index nearest entry and its weighted squared distance.
// A query occupies the block until its result is loaded into the output
// register: the palette ram has one read port, so the scan visits one entry
// per cycle, followed by a three-stage distance pipeline and the result
// hand-off. A finished result sits in an output register, so loads are taken
// while it waits to be collected. Palette entries read before they are loaded
// give arbitrary results. Write configuration only while the block is idle.
module nearest_palette_color_search (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  npcs_pkg::in_word_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output npcs_pkg::out_word_t              out_data,
    input  logic                             cfg_we,
    input  logic [npcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  npcs_pkg::cfg_data_t              cfg_data
);

    npcs_pkg::weight_t    red_weight_reg;
    npcs_pkg::weight_t    green_weight_reg;
    npcs_pkg::weight_t    blue_weight_reg;
    npcs_pkg::cfg_data_t  entries_in_use_reg;
    npcs_pkg::cnt_t       scan_count;
    npcs_pkg::addr_t      last_addr;
    npcs_pkg::weights_t   weights;
    npcs_pkg::ctrl_cmd_t  cmd;
    npcs_pkg::dp_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_weight_reg     <= npcs_pkg::RED_WEIGHT_RST;
            green_weight_reg   <= npcs_pkg::GREEN_WEIGHT_RST;
            blue_weight_reg    <= npcs_pkg::BLUE_WEIGHT_RST;
            entries_in_use_reg <= npcs_pkg::ENTRIES_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                npcs_pkg::CFG_RED_WEIGHT:
                begin
                    red_weight_reg <= cfg_data[npcs_pkg::WEIGHT_W-1:0];
                end
                npcs_pkg::CFG_GREEN_WEIGHT:
                begin
                    green_weight_reg <= cfg_data[npcs_pkg::WEIGHT_W-1:0];
                end
                npcs_pkg::CFG_BLUE_WEIGHT:
                begin
                    blue_weight_reg <= cfg_data[npcs_pkg::WEIGHT_W-1:0];
                end
                npcs_pkg::CFG_ENTRIES_IN_USE:
                begin
                    entries_in_use_reg <= cfg_data;
                end
                default:
                begin
                    red_weight_reg <= red_weight_reg;
                end
            endcase
        end
    end

    // clamp the scan length to 1..ENTRIES
    always_comb
    begin
        if (entries_in_use_reg == '0)
        begin
            scan_count = npcs_pkg::cnt_t'(1);
        end
        else if (int'(entries_in_use_reg) > npcs_pkg::ENTRIES)
        begin
            scan_count = npcs_pkg::cnt_t'(npcs_pkg::ENTRIES);
        end
        else
        begin
            scan_count = npcs_pkg::cnt_t'(entries_in_use_reg);
        end
    end

    assign last_addr = npcs_pkg::addr_t'(scan_count - npcs_pkg::cnt_t'(1));

    assign weights.red_weight   = red_weight_reg;
    assign weights.green_weight = green_weight_reg;
    assign weights.blue_weight  = blue_weight_reg;

    npcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .req_type    (in_data.req_type),
        .entry_index (in_data.entry_index),
        .last_addr   (last_addr),
        .status      (status),
        .in_stall    (in_stall),
        .cmd         (cmd)
    );

    npcs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .weights   (weights),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .status    (status)
    );

endmodule

/* hdl/npcs_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/npcs_ctrl.sv */
// controller: accepts words, sequences the palette scan and result hand-off
// depends on npcs_pkg
module npcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 req_type,
    input  logic [4:0]           entry_index,
    input  npcs_pkg::addr_t      last_addr,
    input  npcs_pkg::dp_status_t status,
    output logic                 in_stall,
    output npcs_pkg::ctrl_cmd_t  cmd
);

    npcs_pkg::state_t state_reg;
    npcs_pkg::state_t state_next;
    npcs_pkg::addr_t  rd_cnt_reg;
    npcs_pkg::addr_t  rd_cnt_next;
    logic             accept;
    logic             load_in_range;

    assign load_in_range = int'(entry_index) < npcs_pkg::ENTRIES;

    // state and scan counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= npcs_pkg::ST_IDLE;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            npcs_pkg::ST_IDLE:
            begin
                if (in_valid && (req_type == npcs_pkg::REQ_QUERY))
                begin
                    state_next = npcs_pkg::ST_SEARCH;
                end
            end
            npcs_pkg::ST_SEARCH:
            begin
                if (rd_cnt_reg == last_addr)
                begin
                    state_next = npcs_pkg::ST_DRAIN;
                end
            end
            npcs_pkg::ST_DRAIN:
            begin
                if (!status.busy && status.out_free)
                begin
                    state_next = npcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    // scan counter
    always_comb
    begin
        rd_cnt_next = rd_cnt_reg;
        if (cmd.capture)
        begin
            rd_cnt_next = '0;
        end
        else if (state_reg == npcs_pkg::ST_SEARCH)
        begin
            rd_cnt_next = rd_cnt_reg + npcs_pkg::addr_t'(1);
        end
    end

    // outputs and commands
    always_comb
    begin
        in_stall     = 1'b1;
        cmd.capture  = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_addr  = rd_cnt_reg;
        cmd.out_load = 1'b0;
        case (state_reg)
            npcs_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid && (req_type == npcs_pkg::REQ_QUERY);
                cmd.wr_en   = in_valid && (req_type == npcs_pkg::REQ_LOAD) && load_in_range;
            end
            npcs_pkg::ST_SEARCH:
            begin
                cmd.rd_en = 1'b1;
            end
            npcs_pkg::ST_DRAIN:
            begin
                cmd.out_load = !status.busy && status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    // a query starts the scan at entry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == npcs_pkg::REQ_QUERY)) |=>
            (state_reg == npcs_pkg::ST_SEARCH) && (rd_cnt_reg == '0))
        else $error("query did not start scan at entry zero");

    // palette writes never overlap a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (!cmd.rd_en && !status.busy))
        else $error("palette write during scan");

    // a result is handed off only after the pipeline is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!status.busy && status.out_free && !accept))
        else $error("result handed off early");

endmodule

/* hdl/npcs_datapath.sv */
// datapath: palette ram, distance pipeline, minimum tracking, output register
// depends on npcs_pkg and npcs_ram
module npcs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  npcs_pkg::ctrl_cmd_t  cmd,
    input  npcs_pkg::in_word_t   in_data,
    input  npcs_pkg::weights_t   weights,
    input  logic                 out_stall,
    output logic                 out_valid,
    output npcs_pkg::out_word_t  out_data,
    output npcs_pkg::dp_status_t status
);

    // query color
    npcs_pkg::color_t q_red_reg;
    npcs_pkg::color_t q_green_reg;
    npcs_pkg::color_t q_blue_reg;

    // pipeline
    npcs_pkg::entry_t rd_entry;
    logic             s1_valid_reg;
    npcs_pkg::addr_t  s1_idx_reg;
    logic             s2_valid_reg;
    npcs_pkg::addr_t  s2_idx_reg;
    npcs_pkg::sq_t    s2_sq_r_reg;
    npcs_pkg::sq_t    s2_sq_g_reg;
    npcs_pkg::sq_t    s2_sq_b_reg;
    logic             s3_valid_reg;
    npcs_pkg::addr_t  s3_idx_reg;
    npcs_pkg::term_t  s3_term_r_reg;
    npcs_pkg::term_t  s3_term_g_reg;
    npcs_pkg::term_t  s3_term_b_reg;

    // running best
    npcs_pkg::addr_t  best_idx_reg;
    npcs_pkg::dist_t  best_dist_reg;

    // output register
    logic                out_valid_reg;
    logic                out_valid_next;
    npcs_pkg::out_word_t out_word_reg;

    npcs_pkg::color_t d_r;
    npcs_pkg::color_t d_g;
    npcs_pkg::color_t d_b;
    npcs_pkg::color_t e_r;
    npcs_pkg::color_t e_g;
    npcs_pkg::color_t e_b;
    npcs_pkg::dist_t  dist_sum;
    logic             take_new;

    // palette store
    npcs_ram #(
        .WIDTH(npcs_pkg::ENTRY_W),
        .DEPTH(npcs_pkg::ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (npcs_pkg::addr_t'(in_data.entry_index)),
        .wdata ({in_data.red, in_data.green, in_data.blue}),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rd_entry)
    );

    // capture query color
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_red_reg   <= in_data.red;
            q_green_reg <= in_data.green;
            q_blue_reg  <= in_data.blue;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // absolute component differences
    assign e_r = rd_entry[3*npcs_pkg::COLOR_W-1 -: npcs_pkg::COLOR_W];
    assign e_g = rd_entry[2*npcs_pkg::COLOR_W-1 -: npcs_pkg::COLOR_W];
    assign e_b = rd_entry[npcs_pkg::COLOR_W-1 -: npcs_pkg::COLOR_W];

    always_comb
    begin
        d_r = (e_r > q_red_reg)   ? (e_r - q_red_reg)   : (q_red_reg - e_r);
        d_g = (e_g > q_green_reg) ? (e_g - q_green_reg) : (q_green_reg - e_g);
        d_b = (e_b > q_blue_reg)  ? (e_b - q_blue_reg)  : (q_blue_reg - e_b);
    end

    // squares, then weighted terms
    always_ff @(posedge clk)
    begin
        s1_idx_reg    <= cmd.rd_addr;
        s2_idx_reg    <= s1_idx_reg;
        s2_sq_r_reg   <= npcs_pkg::sq_t'(d_r) * npcs_pkg::sq_t'(d_r);
        s2_sq_g_reg   <= npcs_pkg::sq_t'(d_g) * npcs_pkg::sq_t'(d_g);
        s2_sq_b_reg   <= npcs_pkg::sq_t'(d_b) * npcs_pkg::sq_t'(d_b);
        s3_idx_reg    <= s2_idx_reg;
        s3_term_r_reg <= npcs_pkg::term_t'(weights.red_weight) * npcs_pkg::term_t'(s2_sq_r_reg);
        s3_term_g_reg <= npcs_pkg::term_t'(weights.green_weight)
                         * npcs_pkg::term_t'(s2_sq_g_reg);
        s3_term_b_reg <= npcs_pkg::term_t'(weights.blue_weight) * npcs_pkg::term_t'(s2_sq_b_reg);
    end

    // sum and compare against the running best, entry zero seeds it
    assign dist_sum = npcs_pkg::dist_t'(s3_term_r_reg) + npcs_pkg::dist_t'(s3_term_g_reg)
                      + npcs_pkg::dist_t'(s3_term_b_reg);
    assign take_new = s3_valid_reg && ((s3_idx_reg == '0) || (dist_sum < best_dist_reg));

    always_ff @(posedge clk)
    begin
        if (take_new)
        begin
            best_idx_reg  <= s3_idx_reg;
            best_dist_reg <= dist_sum;
        end
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg.best_index <= npcs_pkg::best_index_t'(best_idx_reg);
            out_word_reg.min_dist   <= best_dist_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_word_reg;
    assign status.busy     = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    // each read advances through the distance pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("read lost before squaring stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |=> (s3_valid_reg && (s3_idx_reg == $past(s2_idx_reg))))
        else $error("squared entry lost or retagged");

    // a new query never starts over a running scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !status.busy)
        else $error("query captured while pipeline busy");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for nearest_palette_color_search: directed table, palette fill, then random phases
// depends on npcs_pkg and the nearest_palette_color_search top level only
module testbench;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 60;
    localparam int NUM_ROWS      = 21;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_WORDS   = 56;

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        npcs_pkg::cfg_index_t sel;
        npcs_pkg::cfg_data_t  value;
        npcs_pkg::in_word_t   word;
        bit                   typed;
        npcs_pkg::out_word_t  answer;
    } row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    npcs_pkg::in_word_t             in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    npcs_pkg::out_word_t            out_data;
    logic                           cfg_we = 1'b0;
    logic [npcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    npcs_pkg::cfg_data_t            cfg_data = '0;

    // predictor state: palette copy and register shadows
    npcs_pkg::color_t    shadow_red   [npcs_pkg::ENTRIES];
    npcs_pkg::color_t    shadow_green [npcs_pkg::ENTRIES];
    npcs_pkg::color_t    shadow_blue  [npcs_pkg::ENTRIES];
    npcs_pkg::weight_t   w_red   = npcs_pkg::RED_WEIGHT_RST;
    npcs_pkg::weight_t   w_green = npcs_pkg::GREEN_WEIGHT_RST;
    npcs_pkg::weight_t   w_blue  = npcs_pkg::BLUE_WEIGHT_RST;
    npcs_pkg::cfg_data_t use_count = npcs_pkg::ENTRIES_IN_USE_RST;

    npcs_pkg::out_word_t pending_matches [$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        max_gap = 0;
    bit        hold_off_req = 1'b0;
    row_t      directed_rows [NUM_ROWS];

    nearest_palette_color_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // number of entries actually searched for the current register value
    function automatic int search_span();
        if (use_count == 0)
            return 1;
        if (use_count > npcs_pkg::ENTRIES)
            return npcs_pkg::ENTRIES;
        return int'(use_count);
    endfunction

    // weighted nearest entry, lowest index wins ties
    function automatic npcs_pkg::out_word_t predict_match(input npcs_pkg::color_t r,
                                                          input npcs_pkg::color_t g,
                                                          input npcs_pkg::color_t b);
        int                  span;
        int                  dr;
        int                  dg;
        int                  db;
        int                  cand_dist;
        int                  best_dist;
        int                  best;
        npcs_pkg::out_word_t res;
        span = search_span();
        best = 0;
        best_dist = 0;
        for (int i = 0; i < span; i++)
        begin
            dr = int'(shadow_red[i]) - int'(r);
            dg = int'(shadow_green[i]) - int'(g);
            db = int'(shadow_blue[i]) - int'(b);
            cand_dist = int'(w_red) * dr * dr + int'(w_green) * dg * dg
                        + int'(w_blue) * db * db;
            if (i == 0 || cand_dist < best_dist)
            begin
                best = i;
                best_dist = cand_dist;
            end
        end
        res.best_index = npcs_pkg::best_index_t'(best);
        res.min_dist   = npcs_pkg::dist_t'(best_dist);
        return res;
    endfunction

    // table row builders
    function automatic row_t cfg_row(input npcs_pkg::cfg_index_t sel, input int value);
        row_t row;
        row = '{kind: ROW_CFG, sel: sel, value: npcs_pkg::cfg_data_t'(value), word: '0,
                typed: 1'b0, answer: '0};
        return row;
    endfunction

    function automatic row_t load_row(input int idx, input int r, input int g, input int b);
        row_t row;
        row = cfg_row(npcs_pkg::CFG_RED_WEIGHT, 0);
        row.kind = ROW_WORD;
        row.word = '{req_type: npcs_pkg::REQ_LOAD, entry_index: 5'(idx),
                     red: npcs_pkg::color_t'(r), green: npcs_pkg::color_t'(g),
                     blue: npcs_pkg::color_t'(b)};
        return row;
    endfunction

    function automatic row_t query_row(input int r, input int g, input int b);
        row_t row;
        row = load_row(0, r, g, b);
        row.word.req_type = npcs_pkg::REQ_QUERY;
        return row;
    endfunction

    function automatic row_t query_row_is(input int r, input int g, input int b,
                                          input int idx, input int expect_dist);
        row_t row;
        row = query_row(r, g, b);
        row.typed = 1'b1;
        row.answer = '{best_index: npcs_pkg::best_index_t'(idx),
                       min_dist: npcs_pkg::dist_t'(expect_dist)};
        return row;
    endfunction

    // random field values, extremes favored
    function automatic npcs_pkg::color_t pick_color();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return npcs_pkg::color_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_weight();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 15;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic int pick_span();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return 32;
            3: return 63;
            4: return $urandom_range(33, 62);
            default: return $urandom_range(2, 31);
        endcase
    endfunction

    // random word: loads anywhere, queries often aimed at a stored color
    function automatic npcs_pkg::in_word_t random_word();
        npcs_pkg::in_word_t w;
        int                 pick;
        w.entry_index = 5'($urandom_range(0, npcs_pkg::ENTRIES - 1));
        w.red   = pick_color();
        w.green = pick_color();
        w.blue  = pick_color();
        if ($urandom_range(0, 9) < 3)
            w.req_type = npcs_pkg::REQ_LOAD;
        else
        begin
            w.req_type = npcs_pkg::REQ_QUERY;
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, search_span() - 1);
                w.red   = shadow_red[pick];
                w.green = shadow_green[pick];
                w.blue  = shadow_blue[pick];
            end
        end
        return w;
    endfunction

    // offer one word and update the predictor when it is taken
    task automatic send_word(input npcs_pkg::in_word_t w, input bit typed,
                             input npcs_pkg::out_word_t answer);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        if (w.req_type == npcs_pkg::REQ_LOAD)
        begin
            shadow_red[w.entry_index]   = w.red;
            shadow_green[w.entry_index] = w.green;
            shadow_blue[w.entry_index]  = w.blue;
        end
        else
            pending_matches.push_back(typed ? answer : predict_match(w.red, w.green, w.blue));
    endtask

    // sender bursts and gaps
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, max_gap);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // stop offering, wait for every expected result, then let the block settle
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, mirrored into the predictor
    task automatic write_reg(input npcs_pkg::cfg_index_t sel, input npcs_pkg::cfg_data_t value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (sel)
            npcs_pkg::CFG_RED_WEIGHT:     w_red = value[npcs_pkg::WEIGHT_W-1:0];
            npcs_pkg::CFG_GREEN_WEIGHT:   w_green = value[npcs_pkg::WEIGHT_W-1:0];
            npcs_pkg::CFG_BLUE_WEIGHT:    w_blue = value[npcs_pkg::WEIGHT_W-1:0];
            npcs_pkg::CFG_ENTRIES_IN_USE: use_count = value;
            default: ;
        endcase
    endtask

    // receiver stall pattern with a long hold-off on request
    initial
    begin : stall_gen
        int mode;
        int mode_len;
        forever
        begin
            mode = $urandom_range(0, 2);
            mode_len = $urandom_range(30, 200);
            repeat (mode_len)
            begin
                @(posedge clk);
                if (hold_off_req)
                begin
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_off_req = 1'b0;
                end
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 1);
                    default: out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        npcs_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result word: best_index %0d min_dist %0d",
                       out_data.best_index, out_data.min_dist);
                mismatch_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (out_data.best_index !== want.best_index)
                begin
                    $error("best_index: expected %0d, actual %0d",
                           want.best_index, out_data.best_index);
                    mismatch_count++;
                end
                if (out_data.min_dist !== want.min_dist)
                begin
                    $error("min_dist: expected %0d, actual %0d",
                           want.min_dist, out_data.min_dist);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        npcs_pkg::in_word_t w;
        // reset weights 3/4/2 hold until the weight rows
        directed_rows = '{
            cfg_row(npcs_pkg::CFG_ENTRIES_IN_USE, 0),
            load_row(0, 0, 0, 0),
            query_row_is(255, 255, 255, 0, 585225),
            query_row_is(0, 0, 0, 0, 0),
            cfg_row(npcs_pkg::CFG_ENTRIES_IN_USE, 2),
            load_row(1, 255, 255, 255),
            query_row_is(255, 255, 255, 1, 0),
            query_row(128, 64, 200),
            load_row(1, 0, 0, 0),
            query_row(10, 20, 30),
            cfg_row(npcs_pkg::CFG_RED_WEIGHT, 15),
            cfg_row(npcs_pkg::CFG_GREEN_WEIGHT, 15),
            cfg_row(npcs_pkg::CFG_BLUE_WEIGHT, 15),
            query_row_is(255, 255, 255, 0, 2926125),
            cfg_row(npcs_pkg::CFG_RED_WEIGHT, 0),
            cfg_row(npcs_pkg::CFG_GREEN_WEIGHT, 0),
            cfg_row(npcs_pkg::CFG_BLUE_WEIGHT, 0),
            load_row(1, 255, 0, 128),
            query_row_is(37, 200, 90, 0, 0),
            cfg_row(npcs_pkg::CFG_RED_WEIGHT, 1),
            query_row(200, 0, 0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            if (directed_rows[k].kind == ROW_CFG)
            begin
                drain_and_settle();
                write_reg(directed_rows[k].sel, directed_rows[k].value);
            end
            else
                send_word(directed_rows[k].word, directed_rows[k].typed,
                          directed_rows[k].answer);
        end
        drain_and_settle();

        // fill the whole palette so any search width is legal
        max_gap = 10;
        for (int e = 0; e < npcs_pkg::ENTRIES; e++)
        begin
            pace();
            w = '{req_type: npcs_pkg::REQ_LOAD, entry_index: 5'(e), red: pick_color(),
                  green: pick_color(), blue: pick_color()};
            send_word(w, 1'b0, '0);
        end

        // random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_and_settle();
            if (p == 0)
            begin
                write_reg(npcs_pkg::CFG_RED_WEIGHT, npcs_pkg::cfg_data_t'(15));
                write_reg(npcs_pkg::CFG_GREEN_WEIGHT, npcs_pkg::cfg_data_t'(15));
                write_reg(npcs_pkg::CFG_BLUE_WEIGHT, npcs_pkg::cfg_data_t'(15));
                write_reg(npcs_pkg::CFG_ENTRIES_IN_USE, npcs_pkg::cfg_data_t'(63));
            end
            else
            begin
                write_reg(npcs_pkg::CFG_RED_WEIGHT, npcs_pkg::cfg_data_t'(pick_weight()));
                write_reg(npcs_pkg::CFG_GREEN_WEIGHT, npcs_pkg::cfg_data_t'(pick_weight()));
                write_reg(npcs_pkg::CFG_BLUE_WEIGHT, npcs_pkg::cfg_data_t'(pick_weight()));
                write_reg(npcs_pkg::CFG_ENTRIES_IN_USE, npcs_pkg::cfg_data_t'(pick_span()));
            end
            max_gap = (p % 3 == 2 || p == 3) ? 0 : 30;
            burst_left = 0;
            // long receiver hold-off while words keep coming
            if (p == 3)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // sender pause until all results are back
                if (p == 6 && n == PHASE_WORDS / 2)
                    drain_and_settle();
                else
                    pace();
                send_word(random_word(), 1'b0, '0);
            end
        end

        // wind down
        drain_and_settle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
